/* hw/rtl/mklm_pkg.sv */
// ----------------------------------------------------------------------------
// mklm_pkg
// Shared types, constants and helpers for the multi-keyword line matcher.
// ----------------------------------------------------------------------------
package mklm_pkg;

    localparam int SLOTS             = 4;
    localparam int KEYWORDS_DEF      = 4;
    localparam int KEYWORD_BYTES_DEF = 8;
    localparam int KW_W              = 64;
    localparam int CFG_IDX_W         = 3;
    localparam int COUNT_W           = 3;

    // opcodes
    localparam logic OP_BYTE   = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    // report kinds
    localparam logic KIND_LINE    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEYWORD_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEYWORD_A     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEYWORD_B     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEYWORD_C     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEYWORD_D     = 3'd4;

    typedef struct packed {
        logic       opcode;
        logic [7:0] text_byte;
        logic       line_last;
    } t_in_item;

    typedef struct packed {
        logic             report_kind;
        logic             line_selected;
        logic [SLOTS-1:0] line_hit_mask;
        logic [SLOTS-1:0] found_mask;
    } t_out_item;

    // ASCII lower case folds onto upper case, everything else compares exactly
    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c >= 8'h61 && c <= 8'h7A) begin
            return c - 8'h20;
        end
        return c;
    endfunction

endpackage

/* hw/rtl/mklm_scan.sv */
// ----------------------------------------------------------------------------
// mklm_scan
// Parallel window compare: for every keyword slot, checks whether the keyword
// ends at the newest byte of the line window.
// ----------------------------------------------------------------------------
module mklm_scan #(
    parameter int KEYWORD_BYTES = mklm_pkg::KEYWORD_BYTES_DEF,
    parameter int FILL_W        = $clog2(KEYWORD_BYTES + 1)
) (
    input  logic [8*KEYWORD_BYTES-1:0]                  i_window,
    input  logic [FILL_W-1:0]                           i_fill,
    input  logic                                        i_first,
    input  logic [mklm_pkg::SLOTS-1:0][mklm_pkg::KW_W-1:0] i_keywords,
    input  logic [mklm_pkg::COUNT_W-1:0]                i_active,
    output logic [mklm_pkg::SLOTS-1:0]                  o_hits
);

    for (genvar k = 0; k < mklm_pkg::SLOTS; k++) begin : g_slot
        logic [FILL_W-1:0]        kw_len;
        logic [KEYWORD_BYTES-1:0] len_match;
        logic                     sel;
        logic                     hit;

        // keyword length: first zero byte, else the full width
        always_comb begin
            kw_len = FILL_W'(KEYWORD_BYTES);
            for (int j = KEYWORD_BYTES - 1; j >= 0; j--) begin
                if (i_keywords[k][8*j +: 8] == 8'h00) begin
                    kw_len = FILL_W'(j);
                end
            end
        end

        // match assuming each possible length; keyword byte j lines up with
        // window age len-1-j
        for (genvar l = 1; l <= KEYWORD_BYTES; l++) begin : g_len
            logic m;
            always_comb begin
                m = 1'b1;
                for (int j = 0; j < l; j++) begin
                    if (mklm_pkg::fold_case(i_window[8*(l-1-j) +: 8]) !=
                        mklm_pkg::fold_case(i_keywords[k][8*j +: 8])) begin
                        m = 1'b0;
                    end
                end
            end
            assign len_match[l-1] = m;
        end

        always_comb begin
            sel = 1'b0;
            for (int l = 1; l <= KEYWORD_BYTES; l++) begin
                if (kw_len == FILL_W'(l)) begin
                    sel = len_match[l-1];
                end
            end
            if (kw_len == '0) begin
                hit = i_first;
            end else begin
                hit = (i_fill >= kw_len) && sel;
            end
        end

        assign o_hits[k] = (mklm_pkg::COUNT_W'(k) < i_active) && hit;
    end

endmodule

/* hw/rtl/multi_keyword_line_matcher.sv */
// ----------------------------------------------------------------------------
// multi_keyword_line_matcher
// Case-insensitive substring search of up to four keywords in a byte stream
// of lines, with per-line verdicts and a cumulative found mask.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in) carries one text byte per
//   transaction, flagged on the last byte of a line, or a finish command.
//   Output channel (o_out_valid / i_out_stall / o_out) carries a line verdict
//   for every last byte and a summary for every finish.
//   Configuration channel (i_cfg_valid / o_cfg_ready) is always ready; write
//   it only while no transaction is in flight.
//   The input register feeds the result register through the compare logic.
//   Throughput: one transaction per cycle while o_in_stall is low; the window
//   compare over all keyword slots is a single stage of logic.
//   Bytes that produce no result keep moving while the output is stalled; an
//   item that produces a result waits in the input register until the result
//   register frees up, and o_in_stall rises then.
//   Reset clears keywords, keyword count, line state and the found mask, and
//   drops both pipeline registers.
// ----------------------------------------------------------------------------
module multi_keyword_line_matcher #(
    parameter int KEYWORDS      = mklm_pkg::KEYWORDS_DEF,
    parameter int KEYWORD_BYTES = mklm_pkg::KEYWORD_BYTES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  mklm_pkg::t_in_item                i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output mklm_pkg::t_out_item               o_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mklm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mklm_pkg::KW_W-1:0]         i_cfg_data
);

    localparam int WIN_W  = 8 * KEYWORD_BYTES;
    localparam int FILL_W = $clog2(KEYWORD_BYTES + 1);
    localparam int LIMIT  = (KEYWORDS < mklm_pkg::SLOTS) ? KEYWORDS : mklm_pkg::SLOTS;
    localparam int SLOTS  = mklm_pkg::SLOTS;

    // configuration
    logic [mklm_pkg::COUNT_W-1:0]           r_kw_count;
    logic [SLOTS-1:0][mklm_pkg::KW_W-1:0]   r_keywords;
    logic [mklm_pkg::COUNT_W-1:0]           active;

    // input register
    logic                r_s1_valid;
    mklm_pkg::t_in_item  r_s1;

    // line state
    logic [WIN_W-1:0]    r_window, n_window;
    logic [FILL_W-1:0]   r_fill, n_fill;
    logic                r_stopped, n_stopped;
    logic [SLOTS-1:0]    r_hits, n_hits;
    logic [SLOTS-1:0]    r_found, n_found;

    // result register
    logic                r_out_valid, n_out_valid;
    mklm_pkg::t_out_item r_out, n_out;

    logic                in_accept;
    logic                out_free;
    logic                produces;
    logic                s1_go;
    logic                byte_live;
    logic [WIN_W-1:0]    win_shift;
    logic [FILL_W-1:0]   fill_inc;
    logic [SLOTS-1:0]    scan_hits;
    logic [SLOTS-1:0]    hits_now;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kw_count <= '0;
            r_keywords <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                mklm_pkg::CFG_KEYWORD_COUNT: r_kw_count    <= i_cfg_data[mklm_pkg::COUNT_W-1:0];
                mklm_pkg::CFG_KEYWORD_A:     r_keywords[0] <= i_cfg_data;
                mklm_pkg::CFG_KEYWORD_B:     r_keywords[1] <= i_cfg_data;
                mklm_pkg::CFG_KEYWORD_C:     r_keywords[2] <= i_cfg_data;
                mklm_pkg::CFG_KEYWORD_D:     r_keywords[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign active = (r_kw_count > mklm_pkg::COUNT_W'(LIMIT)) ?
                    mklm_pkg::COUNT_W'(LIMIT) : r_kw_count;

    // handshake
    assign out_free   = !r_out_valid || !i_out_stall;
    assign produces   = (r_s1.opcode == mklm_pkg::OP_FINISH) || r_s1.line_last;
    assign s1_go      = r_s1_valid && (!produces || out_free);
    assign o_in_stall = r_s1_valid && !s1_go;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1 <= i_in;
        end
    end

    // window compare on the shifted-in byte
    assign win_shift = (r_window << 8) | WIN_W'(r_s1.text_byte);
    assign fill_inc  = (r_fill == FILL_W'(KEYWORD_BYTES)) ? r_fill : r_fill + FILL_W'(1);
    assign byte_live = !r_stopped && (r_s1.text_byte != 8'h00);

    mklm_scan #(
        .KEYWORD_BYTES (KEYWORD_BYTES),
        .FILL_W        (FILL_W)
    ) u_scan (
        .i_window   (win_shift),
        .i_fill     (fill_inc),
        .i_first    (r_fill == '0),
        .i_keywords (r_keywords),
        .i_active   (active),
        .o_hits     (scan_hits)
    );

    assign hits_now = r_hits | (byte_live ? scan_hits : '0);

    always_comb begin
        n_window    = r_window;
        n_fill      = r_fill;
        n_stopped   = r_stopped;
        n_hits      = r_hits;
        n_found     = r_found;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        if (s1_go) begin
            if (r_s1.opcode == mklm_pkg::OP_FINISH) begin
                n_found                 = '0;
                n_out_valid             = 1'b1;
                n_out.report_kind       = mklm_pkg::KIND_SUMMARY;
                n_out.line_selected     = 1'b0;
                n_out.line_hit_mask     = '0;
                n_out.found_mask        = r_found;
            end else if (r_s1.line_last) begin
                n_window                = '0;
                n_fill                  = '0;
                n_stopped               = 1'b0;
                n_hits                  = '0;
                n_found                 = r_found | hits_now;
                n_out_valid             = 1'b1;
                n_out.report_kind       = mklm_pkg::KIND_LINE;
                n_out.line_selected     = |hits_now;
                n_out.line_hit_mask     = hits_now;
                n_out.found_mask        = r_found | hits_now;
            end else if (!r_stopped) begin
                if (r_s1.text_byte == 8'h00) begin
                    // NUL ends matching for the rest of the line
                    n_stopped = 1'b1;
                end else begin
                    n_window = win_shift;
                    n_fill   = fill_inc;
                    n_hits   = hits_now;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= '0;
            r_fill      <= '0;
            r_stopped   <= 1'b0;
            r_hits      <= '0;
            r_found     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_window    <= n_window;
            r_fill      <= n_fill;
            r_stopped   <= n_stopped;
            r_hits      <= n_hits;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

/* hw/rtl/mklm_checker.sv */
// ----------------------------------------------------------------------------
// mklm_checker
// Port-level checks for the multi-keyword line matcher, bound to the top.
// ----------------------------------------------------------------------------
module mklm_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           o_in_stall,
    input  logic                           o_out_valid,
    input  logic                           i_out_stall,
    input  mklm_pkg::t_out_item            o_out,
    input  logic                           i_cfg_valid,
    input  logic                           o_cfg_ready
);

    // reset empties both pipeline registers
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("pipeline not empty after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed");

    // every keyword hit in a line is part of the found mask reported with it
    a_hits_in_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.report_kind == mklm_pkg::KIND_LINE |->
        (o_out.found_mask & o_out.line_hit_mask) == o_out.line_hit_mask &&
        o_out.line_selected == (|o_out.line_hit_mask))
        else $error("line verdict inconsistent with found mask");

    // a delivered summary clears the found mask: a summary shown in the cycle
    // right after it reports no stale bits, as no line hit can come between
    a_summary_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && o_out.report_kind == mklm_pkg::KIND_SUMMARY ##1
        o_out_valid && o_out.report_kind == mklm_pkg::KIND_SUMMARY |->
        o_out.found_mask == '0)
        else $error("found mask not cleared after summary");

    // the configuration port never blocks
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("configuration write blocked");

endmodule

bind multi_keyword_line_matcher mklm_checker u_mklm_checker (.*);

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-keyword line matcher: directed lines for
// case folding, NUL handling, full-width keywords and finish summaries, then
// randomized text built around the programmed keywords, checked per report.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int RANDOM_ITEMS = 900;
    localparam int PHASES       = 8;
    localparam int DRAIN_CYCLES = 4;
    localparam int STALL_LIMIT  = 500;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_in_valid;
    logic                           o_in_stall;
    mklm_pkg::t_in_item             i_in;
    logic                           o_out_valid;
    logic                           i_out_stall;
    mklm_pkg::t_out_item            o_out;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [mklm_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [mklm_pkg::KW_W-1:0]      i_cfg_data;

    // shadow copy of the keyword registers
    logic [2:0]  kw_count = '0;
    logic [63:0] kw_regs [4] = '{default: '0};

    // shadow line state
    logic [63:0] window      = '0;
    int          window_fill = 0;
    bit          line_halted = 1'b0;
    logic [3:0]  line_hits   = '0;
    logic [3:0]  found_acc   = '0;

    mklm_pkg::t_out_item pending_reports [$];

    int fail_count      = 0;
    int bytes_sent      = 0;
    int finishes_sent   = 0;
    int reports_checked = 0;
    int reg_writes      = 0;
    int idle_cycles     = 0;
    bit idle_on         = 1'b1;

    multi_keyword_line_matcher u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [7:0] fold_letter(input logic [7:0] c);
        if (c >= 8'h61 && c <= 8'h7A) begin
            return c - 8'h20;
        end
        return c;
    endfunction

    function automatic int key_len(input logic [63:0] kw);
        for (int j = 0; j < 8; j++) begin
            if (kw[8*j +: 8] == 8'h00) begin
                return j;
            end
        end
        return 8;
    endfunction

    function automatic logic [7:0] mix_case(input logic [7:0] c);
        if (((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A))
                && $urandom_range(0, 1) == 1) begin
            return c ^ 8'h20;
        end
        return c;
    endfunction

    // keyword bytes: mostly letters, some punctuation next to the letter
    // ranges (must not fold), some anything non-zero
    function automatic logic [7:0] key_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) begin
            return mix_case(8'h41 + 8'($urandom_range(0, 7)));
        end
        if (r < 8) begin
            case ($urandom_range(0, 3))
                0:       return 8'h40;
                1:       return 8'h5B;
                2:       return 8'h60;
                default: return 8'h7B;
            endcase
        end
        return 8'($urandom_range(1, 255));
    endfunction

    // bytes past the terminator stay random, they must be ignored
    function automatic logic [63:0] rand_keyword();
        logic [63:0] kw;
        int          len;
        kw  = {$urandom, $urandom};
        len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
        for (int j = 0; j < 8; j++) begin
            if (j < len) begin
                kw[8*j +: 8] = key_char();
            end else if (j == len) begin
                kw[8*j +: 8] = 8'h00;
            end
        end
        return kw;
    endfunction

    function automatic logic [7:0] text_char();
        int          r;
        logic [63:0] kw;
        int          len;
        r = $urandom_range(0, 99);
        if (r < 2) begin
            return 8'h00;
        end
        if (r < 15) begin
            return 8'($urandom_range(0, 255));
        end
        kw  = kw_regs[$urandom_range(0, 3)];
        len = key_len(kw);
        if (len == 0) begin
            return mix_case(8'h41 + 8'($urandom_range(0, 7)));
        end
        return mix_case(kw[8*$urandom_range(0, len - 1) +: 8]);
    endfunction

    // advance the shadow line state by one accepted transaction and queue
    // the report it produces, if any
    function automatic void predict_report(input mklm_pkg::t_in_item it);
        mklm_pkg::t_out_item rpt;
        int                  n;
        int                  len;
        bit                  hit;
        bit                  first;
        rpt = '0;
        if (it.opcode == mklm_pkg::OP_FINISH) begin
            rpt.report_kind = mklm_pkg::KIND_SUMMARY;
            rpt.found_mask  = found_acc;
            found_acc       = '0;
            pending_reports.push_back(rpt);
            return;
        end
        if (!line_halted) begin
            if (it.text_byte == 8'h00) begin
                line_halted = 1'b1;
            end else begin
                first  = (window_fill == 0);
                window = {window[55:0], it.text_byte};
                if (window_fill < 8) begin
                    window_fill++;
                end
                n = (kw_count > 3'd4) ? 4 : int'(kw_count);
                for (int k = 0; k < n; k++) begin
                    len = key_len(kw_regs[k]);
                    if (len == 0) begin
                        hit = first;
                    end else if (window_fill < len) begin
                        hit = 1'b0;
                    end else begin
                        hit = 1'b1;
                        for (int j = 0; j < len; j++) begin
                            if (fold_letter(window[8*(len-1-j) +: 8])
                                    != fold_letter(kw_regs[k][8*j +: 8])) begin
                                hit = 1'b0;
                            end
                        end
                    end
                    if (hit) begin
                        line_hits[k] = 1'b1;
                    end
                end
            end
        end
        if (!it.line_last) begin
            return;
        end
        found_acc            = found_acc | line_hits;
        rpt.report_kind      = mklm_pkg::KIND_LINE;
        rpt.line_selected    = |line_hits;
        rpt.line_hit_mask    = line_hits;
        rpt.found_mask       = found_acc;
        pending_reports.push_back(rpt);
        window      = '0;
        window_fill = 0;
        line_halted = 1'b0;
        line_hits   = '0;
    endfunction

    task automatic send_item(input logic op, input logic [7:0] b, input logic last);
        mklm_pkg::t_in_item it;
        it.opcode    = op;
        it.text_byte = b;
        it.line_last = last;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= it;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        predict_report(it);
        if (op == mklm_pkg::OP_FINISH) begin
            finishes_sent++;
        end else begin
            bytes_sent++;
        end
    endtask

    // up to eight bytes, first byte in the low byte
    task automatic send_text(input logic [63:0] text, input int n, input bit close);
        for (int i = 0; i < n; i++) begin
            send_item(mklm_pkg::OP_BYTE, text[8*i +: 8], close && (i == n - 1));
        end
    endtask

    task automatic drain_pipeline();
        i_in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [mklm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            mklm_pkg::CFG_KEYWORD_COUNT: kw_count   = data[2:0];
            mklm_pkg::CFG_KEYWORD_A:     kw_regs[0] = data;
            mklm_pkg::CFG_KEYWORD_B:     kw_regs[1] = data;
            mklm_pkg::CFG_KEYWORD_C:     kw_regs[2] = data;
            mklm_pkg::CFG_KEYWORD_D:     kw_regs[3] = data;
            default: ;
        endcase
        reg_writes++;
    endtask

    // sel bit 0 is the count, bits 1..4 keywords A..D
    task automatic reconfigure(input logic [4:0] sel, input logic [2:0] cnt,
                               input logic [3:0][63:0] kws);
        drain_pipeline();
        if (sel[0]) write_reg(mklm_pkg::CFG_KEYWORD_COUNT, 64'(cnt));
        if (sel[1]) write_reg(mklm_pkg::CFG_KEYWORD_A, kws[0]);
        if (sel[2]) write_reg(mklm_pkg::CFG_KEYWORD_B, kws[1]);
        if (sel[3]) write_reg(mklm_pkg::CFG_KEYWORD_C, kws[2]);
        if (sel[4]) write_reg(mklm_pkg::CFG_KEYWORD_D, kws[3]);
        i_cfg_valid <= 1'b0;
    endtask

    // A = "ERR", B empty, C eight bytes with no terminator, D = "@["
    task automatic test_case_folding();
        reconfigure(5'b11111, 3'd4,
                    {64'h5B40, 64'h7F41_7E01_7180_5AFF, 64'h0, 64'h52_5245});
        send_text(64'h72_52_65_5B_40, 5, 1'b1);   // "@[eRr"
        send_text(64'h7B60, 2, 1'b1);             // "`{" is not "@["
    endtask

    task automatic test_nul_stops_line();
        send_text(64'h72_72_65_00, 4, 1'b1);      // leading NUL: nothing, not even empty
        send_text(64'h52_52_00_45, 4, 1'b1);      // "E", NUL, "RR": only the empty keyword
    endtask

    task automatic test_unterminated_keyword();
        send_text(64'h7F_61_7E_01_51_80_7A_FF, 8, 1'b1);
    endtask

    task automatic test_finish_summary();
        send_item(mklm_pkg::OP_FINISH, 8'hFF, 1'b1);
        send_item(mklm_pkg::OP_FINISH, 8'h00, 1'b0);        // mask already cleared
    endtask

    // count above four, finish and a keyword rewrite in the middle of a line
    task automatic test_midline_config();
        send_text(64'h45, 1, 1'b0);
        send_item(mklm_pkg::OP_FINISH, 8'h00, 1'b0);
        reconfigure(5'b00011, 3'd7,
                    {64'h5B40, 64'h7F41_7E01_7180_5AFF, 64'h0, 64'h5845});
        send_text(64'h78, 1, 1'b1);
        send_item(mklm_pkg::OP_FINISH, 8'h78, 1'b0);
    endtask

    task automatic test_random_text();
        logic [3:0][63:0] kws;
        logic [7:0]       line_buf [72];
        logic [2:0]       counts [PHASES];
        logic [4:0]       sel;
        int               line_n;
        int               want;
        int               slot;
        int               klen;
        int               cut;
        int               target;
        counts = '{3'd4, 3'd0, 3'd7, 3'd3, 3'd1, 3'd4, 3'd2, 3'd4};
        for (int p = 0; p < PHASES; p++) begin
            for (int k = 0; k < 4; k++) begin
                kws[k] = (p == 3) ? 64'h0 : (p == 5) ? {64{1'b1}} : rand_keyword();
            end
            sel = (p == 0 || p == 3 || p == 5) ? 5'b11111
                                                : {4'($urandom_range(0, 15)), 1'b1};
            idle_on = (p != 4) && (p != PHASES - 1);
            reconfigure(sel, counts[p], kws);
            target = bytes_sent + finishes_sent + RANDOM_ITEMS / PHASES;
            while (bytes_sent + finishes_sent < target) begin
                if ($urandom_range(0, 14) == 0) begin
                    send_item(mklm_pkg::OP_FINISH, 8'($urandom), 1'($urandom));
                    continue;
                end
                want   = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 60)
                                                     : $urandom_range(1, 20);
                line_n = 0;
                // filler mixed with whole or truncated keywords
                while (line_n < want) begin
                    if ($urandom_range(0, 4) == 0) begin
                        slot = $urandom_range(0, 3);
                        klen = key_len(kw_regs[slot]);
                        cut  = ($urandom_range(0, 1) == 0 || klen < 2)
                               ? klen : $urandom_range(1, klen - 1);
                        for (int j = 0; j < cut; j++) begin
                            line_buf[line_n] = mix_case(kw_regs[slot][8*j +: 8]);
                            line_n++;
                        end
                    end else begin
                        line_buf[line_n] = text_char();
                        line_n++;
                    end
                end
                for (int i = 0; i < line_n; i++) begin
                    if ($urandom_range(0, 39) == 0) begin
                        send_item(mklm_pkg::OP_FINISH, 8'($urandom), 1'($urandom));
                    end
                    send_item(mklm_pkg::OP_BYTE, line_buf[i], i == line_n - 1);
                end
            end
        end
    endtask

    initial begin : out_stall_gen
        int stall_left;
        stall_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                if (stall_left == 0) begin
                    i_out_stall <= 1'b0;
                end
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 9);
                i_out_stall <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : check_reports
        mklm_pkg::t_out_item exp_rpt;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (pending_reports.size() == 0) begin
                $error("report with nothing expected: %h", o_out);
                fail_count++;
            end else begin
                exp_rpt = pending_reports.pop_front();
                reports_checked++;
                if (o_out.report_kind !== exp_rpt.report_kind) begin
                    $error("report_kind: expected %0d, got %0d",
                           exp_rpt.report_kind, o_out.report_kind);
                    fail_count++;
                end
                if (o_out.line_selected !== exp_rpt.line_selected) begin
                    $error("line_selected: expected %0d, got %0d",
                           exp_rpt.line_selected, o_out.line_selected);
                    fail_count++;
                end
                if (o_out.line_hit_mask !== exp_rpt.line_hit_mask) begin
                    $error("line_hit_mask: expected %b, got %b",
                           exp_rpt.line_hit_mask, o_out.line_hit_mask);
                    fail_count++;
                end
                if (o_out.found_mask !== exp_rpt.found_mask) begin
                    $error("found_mask: expected %b, got %b",
                           exp_rpt.found_mask, o_out.found_mask);
                    fail_count++;
                end
            end
        end
    end

    // an input or configuration handshake counts as progress; results alone
    // do not, so a result channel stuck valid cannot keep the run alive
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_stall === 1'b0)
                || (i_cfg_valid && o_cfg_ready === 1'b1)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles, %0d reports outstanding",
                         idle_cycles, pending_reports.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in        <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_case_folding();
        test_nul_stops_line();
        test_unterminated_keyword();
        test_finish_summary();
        test_midline_config();
        test_random_text();
        drain_pipeline();

        $display("Sent %0d text bytes and %0d finish commands, checked %0d reports",
                 bytes_sent, finishes_sent, reports_checked);
        $display("across %0d register writes, keyword counts 0 to 7, %0d mismatches",
                 reg_writes, fail_count);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
